/* hdl/spc_pkg.sv */
package spc_pkg;

	localparam int LEVEL_COUNT_DEF = 256;

	localparam int CW = 8;
	localparam int COLOR_W = 24;
	localparam int P_W = 17;
	localparam logic [P_W-1:0] Q_ONE = 17'h10000;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_PALETTE_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_COLOR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MID_COLOR = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_COLOR = 2'd3;

	localparam logic [COLOR_W-1:0] HIGH_COLOR_RST = 24'hFFFFFF;

	// segment codes
	localparam int SEG_W = 4;
	localparam logic [SEG_W-1:0] SEG_CONST_LOW = 4'd0;
	localparam logic [SEG_W-1:0] SEG_CONST_WHITE = 4'd1;
	localparam logic [SEG_W-1:0] SEG_CONST_HIGH = 4'd2;
	localparam logic [SEG_W-1:0] SEG_SIMPLE_LO = 4'd3;
	localparam logic [SEG_W-1:0] SEG_SIMPLE_HI = 4'd4;
	localparam logic [SEG_W-1:0] SEG_BLUE = 4'd5;
	localparam logic [SEG_W-1:0] SEG_CYAN = 4'd6;
	localparam logic [SEG_W-1:0] SEG_GREEN = 4'd7;
	localparam logic [SEG_W-1:0] SEG_YELLOW = 4'd8;
	localparam logic [SEG_W-1:0] SEG_RED = 4'd9;
	localparam logic [SEG_W-1:0] SEG_MAGENTA = 4'd10;
	localparam logic [SEG_W-1:0] SEG_LAVENDER = 4'd11;

	localparam logic [CW-1:0] C_MAX = 8'd255;
	localparam logic [CW-1:0] C_ZERO = 8'd0;

	// floor(((1-p)*a + p*b)), p in Q1.16 with p <= 1
	function automatic logic [CW-1:0] blend8(input logic [CW-1:0] a, input logic [CW-1:0] b,
			input logic [P_W-1:0] p);
		logic [P_W-1:0] w;
		logic [24:0] s;
		w = Q_ONE - p;
		s = 25'(w) * 25'(a) + 25'(p) * 25'(b);
		return s[23:16];
	endfunction

endpackage

/* hdl/spectrum_palette_colormap_top.sv */
// A request that is accepted shows its color on red/green/blue after four
// register stages: decode, reciprocal multiply, remainder correction, channel
// blend. Throughput: one request per cycle unless out_stall holds the pipeline;
// stages advance independently and fill bubbles.
// Reset (arst_n low, asynchronous): pipeline emptied, palette_mode 0,
// low_color 0, mid_color 0, high_color white.
module spectrum_palette_colormap_top
	import spc_pkg::*;
#(
	parameter int LEVEL_COUNT = LEVEL_COUNT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           level_index,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [CW-1:0]        red,
	output logic [CW-1:0]        green,
	output logic [CW-1:0]        blue,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COLOR_W-1:0]   cfg_data
);

	localparam int DW = $clog2(LEVEL_COUNT);
	localparam int XW = (DW + 4 > 8) ? DW + 4 : 8;
	localparam int OW = DW + 1;
	localparam int NW = OW + 16;
	localparam int K = DW + 16;
	localparam int PW = OW + K + 1;

	localparam logic [XW-1:0] D_X = XW'(LEVEL_COUNT - 1);
	localparam logic [XW-1:0] D2_X = XW'(2 * (LEVEL_COUNT - 1));
	localparam logic [XW-1:0] D3_X = XW'(3 * (LEVEL_COUNT - 1));
	localparam logic [XW-1:0] D4_X = XW'(4 * (LEVEL_COUNT - 1));
	localparam logic [XW-1:0] D5_X = XW'(5 * (LEVEL_COUNT - 1));
	localparam logic [XW-1:0] D7_X = XW'(7 * (LEVEL_COUNT - 1));
	localparam logic [XW-1:0] D8_X = XW'(8 * (LEVEL_COUNT - 1));
	localparam logic [DW-1:0] D_V = DW'(LEVEL_COUNT - 1);
	// floor(2^K / D); quotient estimate is low by at most one
	localparam logic [63:0] RECIP_W = (64'd1 << K) / 64'(LEVEL_COUNT - 1);
	localparam logic [K:0] RECIP = RECIP_W[K:0];
	localparam logic [18:0] LAV_FULL = 19'h40000;

	// configuration registers
	logic               mode_q;
	logic [COLOR_W-1:0] low_q;
	logic [COLOR_W-1:0] mid_q;
	logic [COLOR_W-1:0] high_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			low_q  <= '0;
			mid_q  <= '0;
			high_q <= HIGH_COLOR_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PALETTE_MODE: mode_q <= cfg_data[0];
				REG_LOW_COLOR:    low_q  <= cfg_data;
				REG_MID_COLOR:    mid_q  <= cfg_data;
				REG_HIGH_COLOR:   high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline control
	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	assign en4 = !v_s4 || !out_stall;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_stall = !en1;
	assign out_valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// stage 1: clamp, segment search, offset within segment
	logic [XW-1:0]    ix;
	logic [XW-1:0]    x9;
	logic [XW-1:0]    ix2;
	logic [SEG_W-1:0] seg_d;
	logic [OW-1:0]    off_d;
	logic             half_d;

	always_comb begin
		ix = XW'(level_index);
		if (ix > D_X) ix = D_X;
		x9 = (ix << 3) + ix;
		ix2 = ix << 1;
		seg_d = SEG_CONST_LOW;
		off_d = '0;
		half_d = 1'b0;
		if (ix == '0) begin
			seg_d = SEG_CONST_LOW;
		end else if (!mode_q) begin
			if (ix == D_X) begin
				seg_d = SEG_CONST_WHITE;
			end else if (ix2 <= D_X) begin
				seg_d = SEG_SIMPLE_LO;
				off_d = OW'(ix2);
			end else begin
				seg_d = SEG_SIMPLE_HI;
				off_d = OW'(ix2 - D_X);
			end
		end else if (ix == D_X) begin
			seg_d = SEG_CONST_HIGH;
		end else if (x9 < D2_X) begin
			seg_d = SEG_BLUE;
			off_d = OW'(x9);
			half_d = 1'b1;
		end else if (x9 < D3_X) begin
			seg_d = SEG_CYAN;
			off_d = OW'(x9 - D2_X);
		end else if (x9 < D4_X) begin
			seg_d = SEG_GREEN;
			off_d = OW'(x9 - D3_X);
		end else if (x9 < D5_X) begin
			seg_d = SEG_YELLOW;
			off_d = OW'(x9 - D4_X);
		end else if (x9 < D7_X) begin
			seg_d = SEG_RED;
			off_d = OW'(x9 - D5_X);
			half_d = 1'b1;
		end else if (x9 < D8_X) begin
			seg_d = SEG_MAGENTA;
			off_d = OW'(x9 - D7_X);
		end else begin
			seg_d = SEG_LAVENDER;
			off_d = OW'(x9 - D8_X);
		end
	end

	logic [SEG_W-1:0] seg_s1;
	logic [OW-1:0]    off_s1;
	logic             half_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			seg_s1  <= seg_d;
			off_s1  <= off_d;
			half_s1 <= half_d;
		end
	end

	// stage 2: quotient estimate by reciprocal multiply
	logic [PW-1:0]  prod;
	logic [P_W-1:0] qest_d;

	assign prod = PW'(off_s1) * PW'(RECIP);
	// span 2D shifts one bit further
	assign qest_d = half_s1 ? prod[DW+1 +: P_W] : prod[DW +: P_W];

	logic [SEG_W-1:0] seg_s2;
	logic [OW-1:0]    off_s2;
	logic             half_s2;
	logic [P_W-1:0]   q_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			seg_s2  <= seg_s1;
			off_s2  <= off_s1;
			half_s2 <= half_s1;
			q_s2    <= qest_d;
		end
	end

	// stage 3: remainder check, bump quotient by one if needed
	logic [NW:0]    num;
	logic [NW:0]    qd;
	logic [NW:0]    rem;
	logic [P_W-1:0] p_d;

	always_comb begin
		num = half_s2 ? (NW + 1)'({off_s2, 15'd0}) : (NW + 1)'({off_s2, 16'd0});
		qd = (NW + 1)'(q_s2) * (NW + 1)'(D_V);
		rem = num - qd;
		p_d = (rem >= (NW + 1)'(D_V)) ? q_s2 + 17'd1 : q_s2;
	end

	logic [SEG_W-1:0] seg_s3;
	logic [P_W-1:0]   p_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			seg_s3 <= seg_s2;
			p_s3   <= p_d;
		end
	end

	// stage 4: per-channel endpoints and blend
	logic [CW-1:0] ra, rb, ga, gb, ba, bb;
	logic [CW-1:0] r_d, g_d, b_d;
	logic [25:0]   lav_r;
	logic [CW-1:0] g_blend;

	always_comb begin
		ra = C_ZERO; rb = C_ZERO;
		ga = C_ZERO; gb = C_ZERO;
		ba = C_ZERO; bb = C_ZERO;
		case (seg_s3)
			SEG_CONST_LOW: begin
				ra = low_q[23:16]; rb = low_q[23:16];
				ga = low_q[15:8];  gb = low_q[15:8];
				ba = low_q[7:0];   bb = low_q[7:0];
			end
			SEG_CONST_WHITE: begin
				ra = C_MAX; rb = C_MAX;
				ga = C_MAX; gb = C_MAX;
				ba = C_MAX; bb = C_MAX;
			end
			SEG_CONST_HIGH: begin
				ra = high_q[23:16]; rb = high_q[23:16];
				ga = high_q[15:8];  gb = high_q[15:8];
				ba = high_q[7:0];   bb = high_q[7:0];
			end
			SEG_SIMPLE_LO: begin
				ra = low_q[23:16]; rb = mid_q[23:16];
				ga = low_q[15:8];  gb = mid_q[15:8];
				ba = low_q[7:0];   bb = mid_q[7:0];
			end
			SEG_SIMPLE_HI: begin
				ra = mid_q[23:16]; rb = C_MAX;
				ga = mid_q[15:8];  gb = C_MAX;
				ba = mid_q[7:0];   bb = C_MAX;
			end
			SEG_BLUE: begin
				ra = low_q[23:16];
				ga = low_q[15:8];
				ba = low_q[7:0]; bb = C_MAX;
			end
			SEG_CYAN: begin
				gb = C_MAX;
				ba = C_MAX; bb = C_MAX;
			end
			SEG_GREEN: begin
				ga = C_MAX; gb = C_MAX;
				ba = C_MAX;
			end
			SEG_YELLOW: begin
				rb = C_MAX;
				ga = C_MAX; gb = C_MAX;
			end
			SEG_RED: begin
				ra = C_MAX; rb = C_MAX;
				ga = C_MAX;
			end
			SEG_MAGENTA: begin
				ra = C_MAX; rb = C_MAX;
				bb = C_MAX;
			end
			SEG_LAVENDER: begin
				gb = C_MAX;
				ba = C_MAX; bb = C_MAX;
			end
			default: ;
		endcase

		// lavender red: floor(255 * (4 - p) / 4)
		lav_r = 26'(C_MAX) * 26'(LAV_FULL - 19'(p_s3));
		g_blend = blend8(ga, gb, p_s3);

		r_d = blend8(ra, rb, p_s3);
		g_d = g_blend;
		b_d = blend8(ba, bb, p_s3);
		if (seg_s3 == SEG_LAVENDER) begin
			r_d = lav_r[25:18];
			g_d = g_blend >> 1;
		end
	end

	logic [CW-1:0] red_s4, green_s4, blue_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			red_s4   <= r_d;
			green_s4 <= g_d;
			blue_s4  <= b_d;
		end
	end

	assign red = red_s4;
	assign green = green_s4;
	assign blue = blue_s4;

endmodule

/* tb/spectrum_palette_colormap_top_test.sv */
`timescale 1ns / 100ps

module spectrum_palette_colormap_top_test;
	import spc_pkg::*;

	localparam int LEVELS = LEVEL_COUNT_DEF;
	localparam longint unsigned TOP = LEVELS - 1;
	localparam longint unsigned Q16 = 65536;
	localparam logic MODE_SIMPLE = 1'b0;
	localparam logic MODE_RAINBOW = 1'b1;
	localparam int RAMP_PHASES = 8;
	localparam int RAMP_LEVELS = 250;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 8;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [CW-1:0] r;
		logic [CW-1:0] g;
		logic [CW-1:0] b;
	} rgb_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] level_index = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [CW-1:0] red, green, blue;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [COLOR_W-1:0] cfg_data = '0;

	spectrum_palette_colormap_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .level_index(level_index),
		.out_valid(out_valid), .out_stall(out_stall),
		.red(red), .green(green), .blue(blue),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// shadow copy of the palette registers
	logic sh_mode = MODE_SIMPLE;
	logic [COLOR_W-1:0] sh_low = '0;
	logic [COLOR_W-1:0] sh_mid = '0;
	logic [COLOR_W-1:0] sh_high = HIGH_COLOR_RST;

	logic [7:0] level_q[$];
	rgb_t color_q[$];

	int mismatch_cnt = 0;
	int checked_cnt = 0;
	int setting_cnt = 1;
	longint cycle_cnt = 0;
	logic in_taken = 1'b0;
	logic hold_rx = 1'b0;
	logic flood_go = 1'b0;

	logic [7:0] knee_levels[18] = '{8'd0, 8'd1, 8'd56, 8'd57, 8'd85, 8'd86, 8'd113,
		8'd114, 8'd127, 8'd128, 8'd141, 8'd142, 8'd198, 8'd199, 8'd226, 8'd227,
		8'd254, 8'd255};

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic logic [CW-1:0] clip8(input longint unsigned v);
		return (v > 255) ? 8'd255 : v[7:0];
	endfunction

	function automatic logic [CW-1:0] mix8(input longint unsigned a, input longint unsigned b,
			input longint unsigned p);
		return clip8(((Q16 - p) * a + p * b) >> 16);
	endfunction

	// expected color for one level under the current shadow registers
	function automatic rgb_t map_level(input logic [7:0] idx);
		longint unsigned i, x, p, lo_r, lo_g, lo_b, r, g, b;
		logic [SEG_W-1:0] seg;
		rgb_t res;
		i = idx;
		if (i > TOP)
			i = TOP;
		if (i == 0) begin
			res = rgb_t'(sh_low);
			return res;
		end
		if (sh_mode == MODE_SIMPLE) begin
			if (i >= TOP)
				return '{C_MAX, C_MAX, C_MAX};
			if (2 * i <= TOP) begin
				p = (2 * i * Q16) / TOP;
				res.r = mix8(sh_low[23:16], sh_mid[23:16], p);
				res.g = mix8(sh_low[15:8], sh_mid[15:8], p);
				res.b = mix8(sh_low[7:0], sh_mid[7:0], p);
			end else begin
				p = ((2 * i - TOP) * Q16) / TOP;
				res.r = mix8(sh_mid[23:16], 255, p);
				res.g = mix8(sh_mid[15:8], 255, p);
				res.b = mix8(sh_mid[7:0], 255, p);
			end
			return res;
		end
		if (i >= TOP) begin
			res = rgb_t'(sh_high);
			return res;
		end
		x = 9 * i;
		if (x < 2 * TOP) seg = SEG_BLUE;
		else if (x < 3 * TOP) seg = SEG_CYAN;
		else if (x < 4 * TOP) seg = SEG_GREEN;
		else if (x < 5 * TOP) seg = SEG_YELLOW;
		else if (x < 7 * TOP) seg = SEG_RED;
		else if (x < 8 * TOP) seg = SEG_MAGENTA;
		else seg = SEG_LAVENDER;
		lo_r = sh_low[23:16];
		lo_g = sh_low[15:8];
		lo_b = sh_low[7:0];
		case (seg)
			SEG_BLUE: begin
				p = (x * Q16) / (2 * TOP);
				r = ((Q16 - p) * lo_r) >> 16;
				g = ((Q16 - p) * lo_g) >> 16;
				b = lo_b + ((p * (255 - lo_b)) >> 16);
			end
			SEG_CYAN: begin
				p = ((x - 2 * TOP) * Q16) / TOP;
				r = 0; g = (p * 255) >> 16; b = 255;
			end
			SEG_GREEN: begin
				p = ((x - 3 * TOP) * Q16) / TOP;
				r = 0; g = 255; b = ((Q16 - p) * 255) >> 16;
			end
			SEG_YELLOW: begin
				p = ((x - 4 * TOP) * Q16) / TOP;
				r = (p * 255) >> 16; g = 255; b = 0;
			end
			SEG_RED: begin
				p = ((x - 5 * TOP) * Q16) / (2 * TOP);
				r = 255; g = ((Q16 - p) * 255) >> 16; b = 0;
			end
			SEG_MAGENTA: begin
				p = ((x - 7 * TOP) * Q16) / TOP;
				r = 255; g = 0; b = (p * 255) >> 16;
			end
			default: begin
				// fades toward lavender: red to 3/4, green up to half
				p = ((x - 8 * TOP) * Q16) / TOP;
				r = (255 * (4 * Q16 - p)) / (4 * Q16);
				g = (p * 255) >> 17;
				b = 255;
			end
		endcase
		res.r = clip8(r);
		res.g = clip8(g);
		res.b = clip8(b);
		return res;
	endfunction

	// sender: bursts of requests separated by random gaps
	int burst_left = 0;
	int gap_left = 0;

	always @(negedge clk) begin
		logic nxt_valid;
		logic [7:0] nxt_level;
		nxt_valid = in_valid;
		nxt_level = level_index;
		if (arst_n && !(in_valid && !in_taken)) begin
			nxt_valid = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (level_q.size() > 0) begin
				nxt_valid = 1'b1;
				nxt_level = level_q.pop_front();
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end
		end
		in_valid <= nxt_valid;
		level_index <= nxt_level;
	end

	// receiver: stall pattern changes every so often
	int rx_left = 0;
	int rx_mode = 0;
	logic rx_toggle = 1'b0;

	always @(negedge clk) begin
		logic stall_bit;
		if (rx_left == 0) begin
			rx_left = $urandom_range(16, 200);
			rx_mode = $urandom_range(0, 3);
		end
		rx_left--;
		rx_toggle = ~rx_toggle;
		case (rx_mode)
			0: stall_bit = 1'b0;
			1: stall_bit = 1'($urandom_range(0, 1));
			2: stall_bit = ($urandom_range(0, 4) != 0);
			default: stall_bit = rx_toggle;
		endcase
		out_stall <= hold_rx || stall_bit;
	end

	// long receiver hold-off so the pipeline backs up into in_stall
	initial begin
		wait (flood_go);
		@(posedge clk);
		hold_rx <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_rx <= 1'b0;
	end

	// monitor: register shadow, predict on accept, check on output
	always @(posedge clk) begin
		rgb_t want;
		rgb_t got;
		in_taken <= in_valid && !in_stall;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PALETTE_MODE: sh_mode <= cfg_data[0];
					REG_LOW_COLOR: sh_low <= cfg_data;
					REG_MID_COLOR: sh_mid <= cfg_data;
					REG_HIGH_COLOR: sh_high <= cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				color_q.push_back(map_level(level_index));
			if (out_valid && !out_stall) begin
				got = '{red, green, blue};
				if (color_q.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("[%0t] unexpected color %h %h %h", $realtime, red, green, blue);
				end else begin
					want = color_q.pop_front();
					checked_cnt++;
					if (got !== want) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10)
							$display("[%0t] color mismatch: exp r=%h g=%h b=%h got r=%h g=%h b=%h",
								$realtime, want.r, want.g, want.b, red, green, blue);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d colors outstanding", cycle_cnt,
				color_q.size());
			$display("spectrum_palette_colormap_top regression: fail");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		do @(posedge clk); while (level_q.size() != 0 || in_valid || color_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [COLOR_W-1:0] pick_color();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return COLOR_W'($urandom());
		endcase
	endfunction

	int level_total = 0;

	initial begin
		logic [7:0] lvl;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset palette: simple ramp, black to black to white
		foreach (knee_levels[n])
			if (knee_levels[n] <= 2 || knee_levels[n] >= 127 && knee_levels[n] <= 128 ||
					knee_levels[n] >= 254)
				level_q.push_back(knee_levels[n]);
		level_q.push_back(8'd64);
		wait_idle();

		// rainbow across every segment boundary, including the exact one at 85
		write_reg(REG_PALETTE_MODE, {23'd0, MODE_RAINBOW});
		write_reg(REG_LOW_COLOR, 24'hA0B0C0);
		write_reg(REG_MID_COLOR, 24'h102030);
		write_reg(REG_HIGH_COLOR, 24'h3C5A7E);
		setting_cnt++;
		foreach (knee_levels[n])
			if (knee_levels[n] != 8'd127 && knee_levels[n] != 8'd128)
				level_q.push_back(knee_levels[n]);
		level_q.push_back(8'd170);
		level_total = 7 + 17;
		wait_idle();

		for (int ph = 0; ph < RAMP_PHASES; ph++) begin
			write_reg(REG_PALETTE_MODE, {23'd0, ph[0]});
			if (ph < 2 || $urandom_range(0, 3) != 0) write_reg(REG_LOW_COLOR, pick_color());
			if (ph < 2 || $urandom_range(0, 3) != 0) write_reg(REG_MID_COLOR, pick_color());
			if (ph < 2 || $urandom_range(0, 3) != 0) write_reg(REG_HIGH_COLOR, pick_color());
			setting_cnt++;
			for (int n = 0; n < RAMP_LEVELS; n++) begin
				if ($urandom_range(0, 9) < 3)
					lvl = knee_levels[$urandom_range(0, 17)];
				else
					lvl = 8'($urandom_range(0, 255));
				level_q.push_back(lvl);
			end
			level_total += RAMP_LEVELS;
			if (ph == 2)
				flood_go = 1'b1;
			wait_idle();
		end

		$display("covered %0d levels under %0d palette settings (both modes, color extremes)",
			level_total, setting_cnt);
		$display("checked %0d colors with a %0d-cycle receiver hold-off", checked_cnt,
			HOLD_CYCLES);
		if (mismatch_cnt == 0) begin
			$display("spectrum_palette_colormap_top regression: pass");
		end else begin
			$display("%0d mismatches", mismatch_cnt);
			$display("spectrum_palette_colormap_top regression: fail");
		end
		$finish;
	end

endmodule
